@@ rtl/sclt_pkg.sv @@
// ----------------------------------------------------------------------------
// sclt_pkg
// Types, character codes and sizes shared by the command-line tokenizer.
// ----------------------------------------------------------------------------
package sclt_pkg;

  // Limits of one command line
  localparam int MaxArgs   = 16;
  localparam int WordBytes = 128;

  localparam int WordLenW = $clog2(WordBytes);
  localparam int ArgCntW  = $clog2(MaxArgs + 1);

  // Stream payload widths
  localparam int SDataW = 8;
  localparam int MDataW = 24;
  localparam int MUserW = 3;

  // Character codes
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChBslash = 8'h5C;

  typedef enum logic [4:0] {
    PhBetween    = 5'b00001,
    PhWord       = 5'b00010,
    PhAfterGt    = 5'b00100,
    PhBeforePath = 5'b01000,
    PhAfterAmp   = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteSingle = 2'd1,
    QuoteDouble = 2'd2
  } quote_e;

  typedef enum logic [1:0] {
    KindArg    = 2'd0,
    KindIn     = 2'd1,
    KindTrunc  = 2'd2,
    KindAppend = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatReady = 2'd0,
    StatEmpty = 2'd1,
    StatError = 2'd2
  } status_e;

  typedef struct packed {
    phase_e               phase;
    quote_e               quote;
    logic                 esc;
    logic [WordLenW-1:0]  word_len;
    logic [ArgCntW-1:0]   arg_total;
    logic                 has_in;
    logic                 has_out;
    kind_e                kind;
    logic                 bg;
    logic                 err;
  } state_t;

  localparam state_t StateReset = '{
    phase:     PhBetween,
    quote:     QuoteNone,
    esc:       1'b0,
    word_len:  '0,
    arg_total: '0,
    has_in:    1'b0,
    has_out:   1'b0,
    kind:      KindArg,
    bg:        1'b0,
    err:       1'b0
  };

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] word_byte;
    logic       word_end;
    kind_e      word_kind;
    logic [3:0] arg_index;
    logic       line_done;
    status_e    status;
    logic       background;
    logic [4:0] arg_count;
  } result_t;

endpackage

@@ rtl/sclt_next.sv @@
// ----------------------------------------------------------------------------
// sclt_next
// Next line state and result for one command-line byte.
// ----------------------------------------------------------------------------
module sclt_next import sclt_pkg::*; (
  input  state_t     st_i,
  input  logic [7:0] ch_i,
  input  logic       line_end_i,
  output state_t     st_o,
  output result_t    res_o
);

  localparam int LenCmpW = WordLenW + 1;
  localparam int ArgExtW = ArgCntW + 5;

  state_t             nx;
  logic               done;
  logic               blank;
  logic               wc;
  logic               btw;
  logic               term;
  logic               put;
  logic [7:0]         put_ch;
  logic               o_valid;
  logic [7:0]         o_byte;
  logic               o_end;
  kind_e              o_kind;
  logic [ArgCntW-1:0] o_index;
  status_e            status;
  logic [ArgExtW-1:0] idx_ext;
  logic [ArgExtW-1:0] cnt_ext;

  assign done  = line_end_i || (ch_i == ChNul);
  assign blank = (ch_i == ChSpace) || (ch_i == ChTab);

  always_comb begin
    nx      = st_i;
    wc      = 1'b0;
    btw     = 1'b0;
    term    = 1'b0;
    put     = 1'b0;
    put_ch  = ch_i;
    o_valid = 1'b0;
    o_byte  = '0;
    o_end   = 1'b0;
    o_kind  = KindArg;
    o_index = '0;
    status  = StatReady;

    if (!done && !st_i.err) begin
      unique case (st_i.phase)
        PhWord: begin
          wc = 1'b1;
        end
        PhAfterGt: begin
          nx.phase = PhBeforePath;
          if (ch_i == ChGt) begin
            nx.kind = KindAppend;
          end else begin
            nx.kind = KindTrunc;
            wc      = !blank;
          end
        end
        PhBeforePath: begin
          wc = !blank;
        end
        PhAfterAmp: begin
          if (!blank) nx.err = 1'b1;
        end
        default: begin
          btw = 1'b1;
        end
      endcase

      // open a path word before its first byte
      if (wc && st_i.phase != PhWord) begin
        nx.word_len = '0;
        nx.quote    = QuoteNone;
        nx.esc      = 1'b0;
        nx.phase    = PhWord;
      end

      if (wc) begin
        if (nx.esc) begin
          nx.esc = 1'b0;
          put    = 1'b1;
        end else if (nx.quote == QuoteNone &&
                     (blank || ch_i == ChLt || ch_i == ChGt || ch_i == ChAmp)) begin
          term = 1'b1;
        end else if (nx.quote == QuoteNone && ch_i == ChSquote) begin
          nx.quote = QuoteSingle;
        end else if (nx.quote == QuoteNone && ch_i == ChDquote) begin
          nx.quote = QuoteDouble;
        end else if ((nx.quote == QuoteSingle && ch_i == ChSquote) ||
                     (nx.quote == QuoteDouble && ch_i == ChDquote)) begin
          nx.quote = QuoteNone;
        end else if (ch_i == ChBslash) begin
          nx.esc = 1'b1;
        end else begin
          put = 1'b1;
        end
      end
    end else if (done && !st_i.err) begin
      if (st_i.phase == PhWord) begin
        // a dangling backslash stays in the word
        if (st_i.esc) begin
          nx.esc = 1'b0;
          put    = 1'b1;
          put_ch = ChBslash;
        end
        term = 1'b1;
      end else if (st_i.phase == PhAfterGt || st_i.phase == PhBeforePath) begin
        nx.err = 1'b1;
      end
    end

    if (put) begin
      if (LenCmpW'(nx.word_len) + LenCmpW'(1) >= LenCmpW'(WordBytes)) begin
        nx.err = 1'b1;
      end else begin
        nx.word_len = nx.word_len + WordLenW'(1);
        o_valid     = 1'b1;
        o_byte      = put_ch;
        o_kind      = nx.kind;
        o_index     = (nx.kind == KindArg) ? nx.arg_total : '0;
      end
    end

    if (term && !nx.err) begin
      if (nx.quote != QuoteNone || nx.word_len == '0) begin
        nx.err = 1'b1;
      end else begin
        o_end   = 1'b1;
        o_kind  = nx.kind;
        o_index = (nx.kind == KindArg) ? nx.arg_total : '0;
        if (nx.kind == KindArg) nx.arg_total = nx.arg_total + ArgCntW'(1);
        nx.word_len = '0;
        nx.kind     = KindArg;
        nx.phase    = PhBetween;
        // the separator that closed the word is handled next
        btw         = !done && (st_i.phase == PhWord);
      end
    end

    if (btw && !blank) begin
      if (ch_i == ChAmp) begin
        nx.bg    = 1'b1;
        nx.phase = PhAfterAmp;
      end else if (ch_i == ChLt) begin
        if (nx.has_in) begin
          nx.err = 1'b1;
        end else begin
          nx.has_in = 1'b1;
          nx.kind   = KindIn;
          nx.phase  = PhBeforePath;
        end
      end else if (ch_i == ChGt) begin
        if (nx.has_out) begin
          nx.err = 1'b1;
        end else begin
          nx.has_out = 1'b1;
          nx.phase   = PhAfterGt;
        end
      end else if (nx.arg_total >= ArgCntW'(MaxArgs)) begin
        nx.err = 1'b1;
      end else begin
        // first byte of a new argument word
        nx.kind     = KindArg;
        nx.word_len = '0;
        nx.quote    = QuoteNone;
        nx.esc      = 1'b0;
        nx.phase    = PhWord;
        if (ch_i == ChSquote) begin
          nx.quote = QuoteSingle;
        end else if (ch_i == ChDquote) begin
          nx.quote = QuoteDouble;
        end else if (ch_i == ChBslash) begin
          nx.esc = 1'b1;
        end else begin
          nx.word_len = WordLenW'(1);
          o_valid     = 1'b1;
          o_byte      = ch_i;
          o_kind      = KindArg;
          o_index     = nx.arg_total;
        end
      end
    end

    if (done) begin
      if (nx.err) begin
        status = StatError;
        o_end  = 1'b0;
      end else if (nx.arg_total == '0) begin
        status = StatEmpty;
      end else begin
        status = StatReady;
      end
    end
  end

  assign idx_ext = ArgExtW'(o_index);
  assign cnt_ext = ArgExtW'(nx.arg_total);

  assign st_o = done ? StateReset : nx;

  always_comb begin
    res_o.byte_valid = o_valid;
    res_o.word_byte  = o_byte;
    res_o.word_end   = o_end;
    res_o.word_kind  = (o_valid || o_end) ? o_kind : KindArg;
    res_o.arg_index  = (o_valid || o_end) ? idx_ext[3:0] : 4'd0;
    res_o.line_done  = done;
    res_o.status     = status;
    res_o.background = nx.bg;
    res_o.arg_count  = cnt_ext[4:0];
  end

endmodule

@@ rtl/shell_command_line_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// shell_command_line_tokenizer_core
// Splits a command line, one byte per transfer, into words and redirections.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries one byte of the line, s_axis_tlast ends
// the line (the byte is then ignored); a zero byte also ends the line.
// Output stream: exactly one transfer per input transfer. It flags a word
// byte, a closed word with its kind and argument position, and on the last
// transfer of a line (m_axis_tlast) the line status: ready, empty or error.
// Word bytes are passed on as soon as they are seen; drop them when the line
// ends with error status.
// The result is registered and offered in the cycle after the input
// transfer. One byte is taken every cycle unless a full result register is
// held: the next line state and the result come from one pass of compare and
// select logic between the line state register and the result register. The
// result register accepts a new byte in the same cycle its content is taken,
// so a stalled receiver holds the input back only while the result register is full and not being taken.
// Reset clears the line state and empties the result register; the state
// also returns to its reset value after every line end.
// ----------------------------------------------------------------------------
module shell_command_line_tokenizer_core import sclt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SDataW-1:0] s_axis_tdata,  // character[7:0]
  input  logic              s_axis_tlast,  // line_end
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // word_byte[7:0], word_end[8], arg_index[12:9], status[14:13],
  // background[15], arg_count[20:16], zero[23:21]
  output logic [MDataW-1:0] m_axis_tdata,
  output logic [MUserW-1:0] m_axis_tuser,  // byte_valid[0], word_kind[2:1]
  output logic              m_axis_tlast   // line_done
);

  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;
  logic    accept;

  sclt_next u_next (
    .st_i       (state_q),
    .ch_i       (s_axis_tdata[7:0]),
    .line_end_i (s_axis_tlast),
    .st_o       (state_d),
    .res_o      (res_d)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.arg_count, res_q.background, res_q.status,
                          res_q.arg_index, res_q.word_end, res_q.word_byte};
  assign m_axis_tuser  = {res_q.word_kind, res_q.byte_valid};
  assign m_axis_tlast  = res_q.line_done;

endmodule

@@ verif/tb_shell_command_line_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_shell_command_line_tokenizer_core
// Streams command lines into the tokenizer and checks every result transfer
// against a cycle-free line predictor. A short set of directed lines covers
// operators, quoting, escapes and four parse errors. Random lines follow,
// mostly well formed with random content, plus noise and broken lines, under
// changing idle patterns on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_shell_command_line_tokenizer_core;
  import sclt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic       last;
    logic [7:0] ch;
  } line_item_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [SDataW-1:0] s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [MDataW-1:0] m_axis_tdata;  // word_byte, word_end, arg_index, status, ...
  logic [MUserW-1:0] m_axis_tuser;  // byte_valid, word_kind
  logic              m_axis_tlast;

  shell_command_line_tokenizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  result_t     pending_results[$];
  line_item_t  line_buf[$];
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned rx_hold_req   = 0;
  int unsigned rx_hold_left  = 0;

  // --------------------------------------------------------------------------
  // Line predictor
  // --------------------------------------------------------------------------
  phase_e      tk_phase;
  quote_e      tk_quote;
  logic        tk_esc;
  int unsigned tk_len;
  int unsigned tk_args;
  logic        tk_has_in;
  logic        tk_has_out;
  kind_e       tk_kind;
  logic        tk_bg;
  logic        tk_err;

  logic        ob_valid;
  logic [7:0]  ob_byte;
  logic        ob_end;
  kind_e       ob_kind;
  logic [3:0]  ob_index;

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || c == ChTab;
  endfunction

  function automatic void clear_line_state();
    tk_phase   = PhBetween;
    tk_quote   = QuoteNone;
    tk_esc     = 1'b0;
    tk_len     = 0;
    tk_args    = 0;
    tk_has_in  = 1'b0;
    tk_has_out = 1'b0;
    tk_kind    = KindArg;
    tk_bg      = 1'b0;
    tk_err     = 1'b0;
  endfunction

  function automatic void append_byte(logic [7:0] c);
    if (tk_len + 1 >= WordBytes) begin
      tk_err = 1'b1;
    end else begin
      tk_len++;
      ob_valid = 1'b1;
      ob_byte  = c;
      ob_kind  = tk_kind;
      ob_index = (tk_kind == KindArg) ? tk_args[3:0] : 4'd0;
    end
  endfunction

  // True when c terminates the word and is left for the caller
  function automatic bit word_stops(logic [7:0] c);
    if (tk_esc) begin
      tk_esc = 1'b0;
      append_byte(c);
      return 1'b0;
    end
    if (tk_quote == QuoteNone) begin
      if (is_blank(c) || c == ChLt || c == ChGt || c == ChAmp) return 1'b1;
      if (c == ChSquote) begin
        tk_quote = QuoteSingle;
        return 1'b0;
      end
      if (c == ChDquote) begin
        tk_quote = QuoteDouble;
        return 1'b0;
      end
    end else if ((tk_quote == QuoteSingle && c == ChSquote) ||
                 (tk_quote == QuoteDouble && c == ChDquote)) begin
      tk_quote = QuoteNone;
      return 1'b0;
    end
    if (c == ChBslash) begin
      tk_esc = 1'b1;
      return 1'b0;
    end
    append_byte(c);
    return 1'b0;
  endfunction

  function automatic void open_word(kind_e k);
    tk_kind  = k;
    tk_len   = 0;
    tk_quote = QuoteNone;
    tk_esc   = 1'b0;
    tk_phase = PhWord;
  endfunction

  function automatic void close_word();
    if (tk_quote != QuoteNone || tk_len == 0) begin
      tk_err = 1'b1;
      return;
    end
    ob_end   = 1'b1;
    ob_kind  = tk_kind;
    ob_index = (tk_kind == KindArg) ? tk_args[3:0] : 4'd0;
    if (tk_kind == KindArg) tk_args++;
    tk_len   = 0;
    tk_kind  = KindArg;
    tk_phase = PhBetween;
  endfunction

  function automatic void gap_char(logic [7:0] c);
    if (is_blank(c)) return;
    if (c == ChAmp) begin
      tk_bg    = 1'b1;
      tk_phase = PhAfterAmp;
      return;
    end
    if (c == ChLt) begin
      if (tk_has_in) begin
        tk_err = 1'b1;
        return;
      end
      tk_has_in = 1'b1;
      tk_kind   = KindIn;
      tk_phase  = PhBeforePath;
      return;
    end
    if (c == ChGt) begin
      if (tk_has_out) begin
        tk_err = 1'b1;
        return;
      end
      tk_has_out = 1'b1;
      tk_phase   = PhAfterGt;
      return;
    end
    if (tk_args >= MaxArgs) begin
      tk_err = 1'b1;
      return;
    end
    open_word(KindArg);
    void'(word_stops(c));
  endfunction

  function automatic void path_char(logic [7:0] c);
    if (is_blank(c)) return;
    open_word(tk_kind);
    if (word_stops(c)) close_word();
  endfunction

  function automatic result_t tokenize(logic [7:0] c, logic last);
    result_t r;
    logic    done;
    done     = last || c == ChNul;
    ob_valid = 1'b0;
    ob_byte  = 8'd0;
    ob_end   = 1'b0;
    ob_kind  = KindArg;
    ob_index = 4'd0;
    r.status = StatReady;
    if (!done) begin
      if (!tk_err) begin
        case (tk_phase)
          PhWord: begin
            if (word_stops(c)) begin
              close_word();
              if (!tk_err) gap_char(c);
            end
          end
          PhAfterGt: begin
            tk_phase = PhBeforePath;
            if (c == ChGt) begin
              tk_kind = KindAppend;
            end else begin
              tk_kind = KindTrunc;
              path_char(c);
            end
          end
          PhBeforePath: path_char(c);
          PhAfterAmp: begin
            if (!is_blank(c)) tk_err = 1'b1;
          end
          default: gap_char(c);
        endcase
      end
    end else begin
      if (!tk_err) begin
        if (tk_phase == PhWord) begin
          // a dangling backslash is kept as a literal byte
          if (tk_esc) begin
            tk_esc = 1'b0;
            append_byte(ChBslash);
          end
          if (!tk_err) close_word();
        end else if (tk_phase == PhAfterGt || tk_phase == PhBeforePath) begin
          tk_err = 1'b1;
        end
      end
      r.status = tk_err ? StatError : (tk_args == 0 ? StatEmpty : StatReady);
      if (tk_err) begin
        ob_end = 1'b0;
        if (!ob_valid) ob_kind = KindArg;
      end
    end
    r.byte_valid = ob_valid;
    r.word_byte  = ob_byte;
    r.word_end   = ob_end;
    r.word_kind  = (ob_valid || ob_end) ? ob_kind : KindArg;
    r.arg_index  = (ob_valid || ob_end) ? ob_index : 4'd0;
    r.line_done  = done;
    r.background = tk_bg;
    r.arg_count  = tk_args[4:0];
    if (done) clear_line_state();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side and result check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result transfer, expected none, actual %h/%h/%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("byte_valid", exp_r.byte_valid, m_axis_tuser[0]);
        compare_field("word_kind", exp_r.word_kind, m_axis_tuser[2:1]);
        compare_field("word_byte", exp_r.word_byte, m_axis_tdata[7:0]);
        compare_field("word_end", exp_r.word_end, m_axis_tdata[8]);
        compare_field("arg_index", exp_r.arg_index, m_axis_tdata[12:9]);
        compare_field("status", exp_r.status, m_axis_tdata[14:13]);
        compare_field("background", exp_r.background, m_axis_tdata[15]);
        compare_field("arg_count", exp_r.arg_count, m_axis_tdata[20:16]);
        compare_field("pad", 0, m_axis_tdata[23:21]);
        compare_field("line_done", exp_r.line_done, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  task automatic send_char(logic [7:0] c, logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(tokenize(c, last));
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic play_line();
    foreach (line_buf[i]) send_char(line_buf[i].ch, line_buf[i].last);
    line_buf.delete();
  endtask

  task automatic push_ch(logic [7:0] c);
    line_buf.push_back('{last: 1'b0, ch: c});
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endtask

  task automatic push_end(logic [7:0] c);
    line_buf.push_back('{last: 1'b1, ch: c});
  endtask

  task automatic push_blanks();
    repeat ($urandom_range(1, 2)) push_ch($urandom_range(1) ? ChSpace : ChTab);
  endtask

  // Byte that is never a separator, quote, escape or operator
  function automatic logic [7:0] plain_char();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 8) return 8'($urandom_range(8'h30, 8'h39));
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  task automatic push_word(int unsigned n);
    int unsigned r;
    logic [7:0]  q;
    for (int unsigned j = 0; j < n; j++) begin
      r = (n > 100) ? 0 : $urandom_range(99);
      if (r < 72) begin
        push_ch(plain_char());
      end else if (r < 84) begin
        push_ch(ChBslash);
        push_ch(8'($urandom_range(1, 255)));
      end else if (r < 96) begin
        q = $urandom_range(1) ? ChSquote : ChDquote;
        push_ch(q);
        repeat ($urandom_range(0, 3)) push_ch($urandom_range(3) == 0 ? ChSpace : plain_char());
        // leave a quote open now and then
        if ($urandom_range(99) < 95) push_ch(q);
      end else begin
        push_ch(ChBslash);
        push_ch($urandom_range(1) ? ChBslash : ChSpace);
      end
    end
  endtask

  task automatic build_random_line();
    int unsigned nwords;
    int unsigned wlen;
    int unsigned r;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 24)) push_ch(8'($urandom_range(255)));
    end else begin
      nwords = ($urandom_range(99) < 4) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      if ($urandom_range(1)) push_blanks();
      for (int unsigned i = 0; i < nwords; i++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          push_ch(ChLt);
        end else if (r < 14) begin
          push_ch(ChGt);
        end else if (r < 18) begin
          push_ch(ChGt);
          push_ch(ChGt);
        end
        if (r < 18 && $urandom_range(1)) push_blanks();
        if ($urandom_range(99) < 2) wlen = $urandom_range(120, 135);
        else wlen = (nwords > 8) ? 1 : $urandom_range(1, 6);
        push_word(wlen);
        if ($urandom_range(9) != 0) push_blanks();
      end
      if ($urandom_range(99) < 12) begin
        push_ch(ChAmp);
        r = $urandom_range(9);
        if (r < 3) push_blanks();
        else if (r == 3) push_ch(plain_char());
      end
    end
    if ($urandom_range(99) < 85) push_end(8'($urandom_range(255)));
    else push_ch(ChNul);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_words_and_background();
    push_ch(8'hFF);
    push_str("\tb&");
    push_end(8'hFF);
    play_line();
  endtask

  task automatic test_quotes_and_trailing_escape();
    push_str("'x'\\");
    push_ch(ChNul);
    play_line();
  endtask

  task automatic test_redirections_only();
    push_str("<i>>o");
    push_end(8'h00);
    play_line();
  endtask

  task automatic test_parse_errors();
    push_str(">");            // path missing after operator
    push_end(8'h41);
    push_str("\"a");          // quote still open at line end
    push_end(8'h20);
    push_str("&x");           // text after background marker
    push_end(8'h7F);
    push_str("<a<");          // second input redirection
    push_end(8'h80);
    play_line();
  endtask

  task automatic test_random_lines(int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      build_random_line();
      play_line();
    end
  endtask

  task automatic test_receiver_hold();
    rx_hold_req = 300;
    test_random_lines(80);
    wait_results_drained();
  endtask

  initial begin
    clear_line_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 25;
    rx_idle_pct = 72;
    test_words_and_background();
    test_quotes_and_trailing_escape();
    test_redirections_only();
    test_parse_errors();
    wait_results_drained();
    test_random_lines(400);
    wait_results_drained();
    test_receiver_hold();

    tx_idle_pct = 72;
    rx_idle_pct = 25;
    test_random_lines(400);
    wait_results_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_lines(400);
    wait_results_drained();
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
